// ===== rtl/pa_pkg.sv =====
package pa_pkg;

  localparam int IndexW      = 16;
  localparam int IndexBitsDef = 16;
  localparam int PaddrW      = 3;
  localparam int PdataW      = 32;

  typedef enum logic [2:0] {
    PtPoints    = 3'd0,
    PtLines     = 3'd1,
    PtStrip     = 3'd2,
    PtLoop      = 3'd3,
    PtTriangles = 3'd4,
    PtFan       = 3'd5,
    PtQuads     = 3'd6,
    PtQuadStrip = 3'd7
  } prim_type_e;

  typedef enum logic [1:0] {
    KindPoint    = 2'd0,
    KindEdge     = 2'd1,
    KindTriangle = 2'd2,
    KindEnd      = 2'd3
  } prim_kind_e;

  typedef struct packed {
    logic [IndexW-1:0] vertex_index;
    logic              last_vertex;
  } vertex_t;

  typedef struct packed {
    logic [1:0]        prim_kind;
    logic [IndexW-1:0] index_a;
    logic [IndexW-1:0] index_b;
    logic [IndexW-1:0] index_c;
    logic              run_last;
    logic              batch_end;
  } prim_t;

  // up to two results caused by one vertex
  typedef struct packed {
    logic [1:0] cnt;
    prim_t      r0;
    prim_t      r1;
  } prim_pair_t;

  // position of the vertex that closes a group
  function automatic logic [1:0] group_last(prim_type_e t);
    logic [1:0] g;
    unique case (t)
      PtLines:     g = 2'd1;
      PtTriangles: g = 2'd2;
      PtQuads:     g = 2'd3;
      PtQuadStrip: g = 2'd1;
      default:     g = 2'd0;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/primitive_assembly.sv =====
// channel  | direction | payload   | handshake
// ---------+-----------+-----------+---------------------------
// in       | input     | vertex_t  | in_valid_i / in_stall_o
// out      | output    | prim_t    | out_valid_o / out_stall_i
// apb      | input     | 32-bit    | psel/penable/pwrite, paddr
//
// one vertex per cycle unless the output stalls; a vertex that forms two
// primitives holds the input while the buffer drains its second entry.
// a vertex passes two registers: input register, then the result buffer.
// reset clears the type to points and starts a fresh batch.
// out_stall_i backs up through the result buffer to the input register.
module primitive_assembly import pa_pkg::*; #(
  parameter int IndexBits = IndexBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vertex_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output prim_t             out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic       in_vld_q, in_vld_d;
  vertex_t    in_q;
  logic       can_load;
  logic       fire;
  logic       accept;
  prim_type_e prim_type;
  logic       type_wr;
  prim_pair_t pair;

  assign fire       = in_vld_q && can_load;
  assign in_stall_o = in_vld_q && !can_load;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  pa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .prim_type_o (prim_type),
    .type_wr_o   (type_wr)
  );

  pa_core #(
    .IndexBits (IndexBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .prim_type_i (prim_type),
    .type_wr_i   (type_wr),
    .fire_i      (fire),
    .vertex_i    (in_q),
    .pair_o      (pair)
  );

  pa_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .pair_i      (pair),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/pa_cfg.sv =====
module pa_cfg import pa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output prim_type_e        prim_type_o,
  output logic              type_wr_o
);

  prim_type_e type_q, type_d;
  logic       hit;

  assign pready    = 1'b1;
  assign hit       = (paddr[PaddrW-1] == 1'b0);
  assign type_wr_o = psel && penable && pwrite && pready && hit;

  always_comb begin
    type_d = type_q;
    if (type_wr_o) begin
      type_d = prim_type_e'(pwdata[2:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q <= PtPoints;
    end else begin
      type_q <= type_d;
    end
  end

  assign prdata      = hit ? PdataW'(type_q) : '0;
  assign prim_type_o = type_q;

endmodule

// ===== rtl/pa_core.sv =====
module pa_core import pa_pkg::*; #(
  parameter int IndexBits = IndexBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  prim_type_e  prim_type_i,
  input  logic        type_wr_i,
  input  logic        fire_i,
  input  vertex_t     vertex_i,
  output prim_pair_t  pair_o
);

  localparam int StoreW = (IndexBits < IndexW) ? IndexBits : IndexW;

  logic [StoreW-1:0] first_q, first_d;
  logic [StoreW-1:0] hist_q [3];
  logic [StoreW-1:0] hist_d [3];
  logic [1:0]        phase_q, phase_d;
  logic [1:0]        seen_q, seen_d;

  logic [StoreW-1:0] v;
  logic [StoreW-1:0] first;
  logic              last;
  logic              done;
  logic [1:0]        glast;
  prim_pair_t        pair;

  function automatic prim_t mk(prim_kind_e k, logic [StoreW-1:0] a,
                               logic [StoreW-1:0] b, logic [StoreW-1:0] c);
    prim_t r;
    r.prim_kind = k;
    r.index_a   = IndexW'(a);
    r.index_b   = IndexW'(b);
    r.index_c   = IndexW'(c);
    r.run_last  = 1'b0;
    r.batch_end = 1'b0;
    return r;
  endfunction

  assign v     = vertex_i.vertex_index[StoreW-1:0];
  assign last  = vertex_i.last_vertex;
  assign glast = group_last(prim_type_i);
  assign done  = (phase_q == glast);
  assign first = (seen_q == 2'd0) ? v : first_q;

  always_comb begin
    pair.cnt = 2'd0;
    pair.r0  = '0;
    pair.r1  = '0;
    unique case (prim_type_i)
      PtPoints: begin
        pair.r0  = mk(KindPoint, v, '0, '0);
        pair.cnt = 2'd1;
      end
      PtLines: begin
        if (done) begin
          pair.r0  = mk(KindEdge, hist_q[0], v, '0);
          pair.cnt = 2'd1;
        end
      end
      PtStrip: begin
        if (seen_q != 2'd0) begin
          pair.r0  = mk(KindEdge, hist_q[0], v, '0);
          pair.cnt = 2'd1;
        end
      end
      PtLoop: begin
        if (seen_q != 2'd0) begin
          pair.r0  = mk(KindEdge, hist_q[0], v, '0);
          pair.cnt = 2'd1;
          if (last) begin
            // closing edge back to the first vertex
            pair.r1  = mk(KindEdge, v, first, '0);
            pair.cnt = 2'd2;
          end
        end
      end
      PtTriangles: begin
        if (done) begin
          pair.r0  = mk(KindTriangle, hist_q[1], hist_q[0], v);
          pair.cnt = 2'd1;
        end
      end
      PtFan: begin
        if (seen_q >= 2'd2) begin
          pair.r0  = mk(KindTriangle, first, hist_q[0], v);
          pair.cnt = 2'd1;
        end
      end
      PtQuads: begin
        if (done) begin
          pair.r0  = mk(KindTriangle, hist_q[2], hist_q[1], hist_q[0]);
          pair.r1  = mk(KindTriangle, hist_q[0], v, hist_q[2]);
          pair.cnt = 2'd2;
        end
      end
      PtQuadStrip: begin
        if (done && seen_q == 2'd3) begin
          pair.r0  = mk(KindTriangle, hist_q[2], hist_q[1], hist_q[0]);
          pair.r1  = mk(KindTriangle, hist_q[1], v, hist_q[0]);
          pair.cnt = 2'd2;
        end
      end
    endcase
    if (last && pair.cnt == 2'd0) begin
      pair.r0  = mk(KindEnd, '0, '0, '0);
      pair.cnt = 2'd1;
    end
    if (pair.cnt == 2'd1) begin
      pair.r0.run_last  = 1'b1;
      pair.r0.batch_end = last;
    end else if (pair.cnt == 2'd2) begin
      pair.r1.run_last  = 1'b1;
      pair.r1.batch_end = last;
    end
  end

  assign pair_o = pair;

  always_comb begin
    first_d = first_q;
    hist_d  = hist_q;
    phase_d = phase_q;
    seen_d  = seen_q;
    if (type_wr_i) begin
      phase_d = 2'd0;
      seen_d  = 2'd0;
    end else if (fire_i) begin
      if (last) begin
        phase_d = 2'd0;
        seen_d  = 2'd0;
      end else begin
        first_d   = first;
        hist_d[2] = hist_q[1];
        hist_d[1] = hist_q[0];
        hist_d[0] = v;
        phase_d   = (phase_q >= glast) ? 2'd0 : phase_q + 2'd1;
        if (seen_q != 2'd3) begin
          seen_d = seen_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      hist_q  <= '{default: '0};
      phase_q <= 2'd0;
      seen_q  <= 2'd0;
    end else begin
      first_q <= first_d;
      hist_q  <= hist_d;
      phase_q <= phase_d;
      seen_q  <= seen_d;
    end
  end

`ifndef ASSERT_OFF
  a_phase_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= glast)
    else $error("group phase beyond group size");
  a_batch_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last |=> seen_q == 2'd0 && phase_q == 2'd0)
    else $error("batch state not cleared after last vertex");
  a_fresh_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q == 2'd0 |-> phase_q == 2'd0)
    else $error("phase set on empty batch");
`endif

endmodule

// ===== rtl/pa_outbuf.sv =====
module pa_outbuf import pa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  prim_pair_t pair_i,
  output logic       can_load_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output prim_t      out_data_o
);

  logic [1:0] cnt_q, cnt_d;
  prim_t      r0_q, r0_d;
  prim_t      r1_q, r1_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  // empty at this edge once the head leaves
  assign can_load_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
  assign out_data_o  = r0_q;

  always_comb begin
    cnt_d = cnt_q;
    r0_d  = r0_q;
    r1_d  = r1_q;
    if (load_i) begin
      cnt_d = pair_i.cnt;
      r0_d  = pair_i.r0;
      r1_d  = pair_i.r1;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      r0_d  = r1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer overfilled");
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.batch_end |-> out_data_o.run_last)
    else $error("batch end not on last result of its vertex");
`endif

endmodule
